@@ rtl/core/sots_pkg.sv @@
// Shared types and constants for the sensor offset trim search core.
// No dependencies; imported by every module of the core.
`default_nettype none

package sots_pkg;

    // Request codes on req_type
    localparam logic [1:0] REQ_START      = 2'd0;
    localparam logic [1:0] REQ_SAMPLE     = 2'd1;
    localparam logic [1:0] REQ_TIME_UP    = 2'd2;
    localparam logic [1:0] REQ_WRITE_DONE = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY_NEEDED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP  = 2'd3;

    // Register reset values
    localparam logic [9:0] TARGET_LEVEL_RST  = 10'h200;
    localparam logic [8:0] WINDOW_HALF_RST   = 9'h010;
    localparam logic [3:0] STEADY_NEEDED_RST = 4'd3;
    localparam logic [7:0] INITIAL_STEP_RST  = 8'h40;

    typedef struct packed {
        logic [9:0] target_level;
        logic [8:0] window_half;
        logic [3:0] steady_needed;
        logic [7:0] initial_step;
    } cfg_t;

    typedef struct packed {
        logic       cal_active;
        logic [7:0] step_now;
        logic [7:0] wiper_value;
        logic       was_high;
        logic [3:0] steady_run;
        logic       time_up;
        logic       active_axis;
    } state_t;

    localparam state_t STATE_RST = '{
        cal_active:  1'b0,
        step_now:    8'd0,
        wiper_value: 8'd0,
        was_high:    1'b0,
        steady_run:  4'd0,
        time_up:     1'b0,
        active_axis: 1'b0
    };

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] axis_select;
        logic       sample_port;
        logic [9:0] sample_value;
        logic [7:0] sample_flags;
    } item_t;

    typedef struct packed {
        logic       pot_write;
        logic       pot_channel;
        logic [7:0] pot_setting;
        logic       data_valid;
        logic       data_port;
        logic [9:0] data_value;
        logic [7:0] data_flags;
        logic       sample_request;
        logic       sample_axis;
        logic       calibrating;
        logic       bad_axis;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/sensor_offset_trim_search_core.sv @@
// Sensor offset trim search core: step-halving walk of a pot wiper toward an ADC band.
// Path: an accepted request waits in the input register, then its result in the result register.
// Throughput: one request per cycle while results are taken; the step logic between the registers is combinational.
// Reset: rst_n async, active low; clears state and both valid bits, loads config reset values (payloads unreset).
// Config registers reset to target 512, window 16, steady 3, initial step 64.
// Depends on sots_pkg, sots_cfg_regs and sots_step.
`default_nettype none

module sensor_offset_trim_search_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sots_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sots_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire logic [1:0]                      req_type,
    input  wire logic [7:0]                      axis_select,
    input  wire logic                            sample_port,
    input  wire logic [9:0]                      sample_value,
    input  wire logic [7:0]                      sample_flags,
    // result channel
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic                                 pot_write,
    output logic                                 pot_channel,
    output logic [7:0]                           pot_setting,
    output logic                                 data_valid,
    output logic                                 data_port,
    output logic [9:0]                           data_value,
    output logic [7:0]                           data_flags,
    output logic                                 sample_request,
    output logic                                 sample_axis,
    output logic                                 calibrating,
    output logic                                 bad_axis
);
    import sots_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    item_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_vld_reg;
    logic    advance;   // request in the input register moves to the result register

    sots_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sots_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Result register frees when empty or being taken; the input register
    // frees when empty or advancing, so one request per cycle flows through.
    assign advance   = item_vld_reg && (!res_vld_reg || res_ready);
    assign req_ready = !item_vld_reg || advance;

    // Input register: control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            item_vld_reg <= req_valid;
        end
    end

    // Input register: payload, no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg.req_type     <= req_type;
            item_reg.axis_select  <= axis_select;
            item_reg.sample_port  <= sample_port;
            item_reg.sample_value <= sample_value;
            item_reg.sample_flags <= sample_flags;
        end
    end

    // Search state commits together with the result it produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= STATE_RST;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg   <= state_next;
                res_vld_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid      = res_vld_reg;
    assign pot_write      = res_reg.pot_write;
    assign pot_channel    = res_reg.pot_channel;
    assign pot_setting    = res_reg.pot_setting;
    assign data_valid     = res_reg.data_valid;
    assign data_port      = res_reg.data_port;
    assign data_value     = res_reg.data_value;
    assign data_flags     = res_reg.data_flags;
    assign sample_request = res_reg.sample_request;
    assign sample_axis    = res_reg.sample_axis;
    assign calibrating    = res_reg.calibrating;
    assign bad_axis       = res_reg.bad_axis;

    // State only moves when a request advances
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("search state changed without a request");

    // A bad axis always leaves calibration off
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.bad_axis) |-> !res_reg.calibrating)
        else $error("bad axis left calibration on");

    // Pass-through data only appears outside calibration
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.data_valid) |-> (!res_reg.calibrating && !res_reg.pot_write))
        else $error("sample passed through while calibrating");

    // Each result carries at most one action
    assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> $onehot0({res_reg.pot_write, res_reg.data_valid,
                                  res_reg.sample_request, res_reg.bad_axis}))
        else $error("result carries more than one action");

    // The result register is never overwritten while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_ready) |-> !advance)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/core/sots_cfg_regs.sv @@
// Configuration register file for the trim search core.
// Depends on sots_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module sots_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sots_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sots_pkg::CFG_DATA_W-1:0] cfg_data,
    output sots_pkg::cfg_t                       cfg
);
    import sots_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level  <= TARGET_LEVEL_RST;
            cfg_reg.window_half   <= WINDOW_HALF_RST;
            cfg_reg.steady_needed <= STEADY_NEEDED_RST;
            cfg_reg.initial_step  <= INITIAL_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARGET_LEVEL:  cfg_reg.target_level  <= cfg_data[9:0];
                CFG_WINDOW_HALF:   cfg_reg.window_half   <= cfg_data[8:0];
                CFG_STEADY_NEEDED: cfg_reg.steady_needed <= cfg_data[3:0];
                CFG_INITIAL_STEP:  cfg_reg.initial_step  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sots_step.sv @@
// Next-state and result logic for one request of the trim search.
// Purely combinational; depends on sots_pkg.
`default_nettype none

module sots_step (
    input  wire sots_pkg::cfg_t   cfg,
    input  wire sots_pkg::state_t st,
    input  wire sots_pkg::item_t  item,
    output sots_pkg::state_t      st_next,
    output sots_pkg::result_t     res
);
    import sots_pkg::*;

    logic [10:0] band_hi;
    logic [9:0]  band_lo;
    logic        lo_exists;
    logic        above;
    logic        below;
    logic [7:0]  step_half;

    assign band_hi   = {1'b0, cfg.target_level} + {2'b00, cfg.window_half};
    assign lo_exists = ({1'b0, cfg.window_half} <= cfg.target_level);
    assign band_lo   = cfg.target_level - {1'b0, cfg.window_half};
    assign above     = ({1'b0, item.sample_value} > band_hi);
    assign below     = lo_exists && (item.sample_value < band_lo);
    // halve on reversal, but a step of 1 stays 1
    assign step_half = (st.step_now == 8'd1) ? st.step_now : {1'b0, st.step_now[7:1]};

    always_comb
    begin
        st_next = st;
        res     = '0;
        case (item.req_type)
            REQ_START:
            begin
                if (item.axis_select <= 8'd1)
                begin
                    st_next.cal_active  = 1'b1;
                    st_next.step_now    = cfg.initial_step;
                    st_next.wiper_value = 8'd0;
                    st_next.was_high    = 1'b1;
                    st_next.steady_run  = 4'd0;
                    st_next.time_up     = 1'b0;
                    st_next.active_axis = item.axis_select[0];
                    res.pot_write       = 1'b1;
                    res.pot_channel     = item.axis_select[0];
                end
                else
                begin
                    res.bad_axis       = 1'b1;
                    st_next.cal_active = 1'b0;
                end
            end
            REQ_SAMPLE:
            begin
                if (!st.cal_active)
                begin
                    res.data_valid = 1'b1;
                    res.data_port  = item.sample_port;
                    res.data_value = item.sample_value;
                    res.data_flags = item.sample_flags;
                end
                else if (above)
                begin
                    st_next.step_now    = st.was_high ? st.step_now : step_half;
                    st_next.wiper_value = st.wiper_value + st_next.step_now;
                    st_next.was_high    = 1'b1;
                    st_next.steady_run  = 4'd0;
                    res.pot_write       = 1'b1;
                    res.pot_channel     = item.sample_port;
                    res.pot_setting     = st_next.wiper_value;
                end
                else if (below)
                begin
                    st_next.step_now    = st.was_high ? step_half : st.step_now;
                    st_next.wiper_value = st.wiper_value - st_next.step_now;
                    st_next.was_high    = 1'b0;
                    st_next.steady_run  = 4'd0;
                    res.pot_write       = 1'b1;
                    res.pot_channel     = item.sample_port;
                    res.pot_setting     = st_next.wiper_value;
                end
                else if (st.steady_run < cfg.steady_needed)
                begin
                    st_next.steady_run = st.steady_run + 4'd1;
                    res.pot_write      = 1'b1;
                    res.pot_channel    = item.sample_port;
                    res.pot_setting    = st.wiper_value;
                end
                else
                begin
                    // in band long enough: done, no write
                    st_next.cal_active = 1'b0;
                end
            end
            REQ_TIME_UP:
            begin
                st_next.time_up = 1'b1;
            end
            REQ_WRITE_DONE:
            begin
                if (!st.time_up)
                begin
                    res.sample_request = 1'b1;
                    res.sample_axis    = st.active_axis;
                end
                else
                begin
                    st_next.cal_active = 1'b0;
                end
            end
            default: ;
        endcase
        res.calibrating = st_next.cal_active;
    end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking bench for sensor_offset_trim_search_core: requests, predicted results, checks.
// Depends on sots_pkg and the core RTL only; no files or arguments are read.
`timescale 1ns / 100ps

module tb;
    import sots_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SEG_ITEMS   = 155;   // random requests per register setting
    localparam int NUM_SEGS    = 6;
    localparam int HOLD_CYCLES = 80;    // long result back-pressure stretch

    // sample placement relative to the accepted band
    localparam int PICK_IN   = 0;
    localparam int PICK_HIGH = 1;
    localparam int PICK_LOW  = 2;
    localparam int PICK_ANY  = 3;

    // ------------------------------------------------------------------
    // Clock, reset and DUT-facing signals (DUT inputs start at known values)
    // ------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  req_valid    = 1'b0;
    logic                  req_ready;
    logic [1:0]            req_type     = '0;
    logic [7:0]            axis_select  = '0;
    logic                  sample_port  = 1'b0;
    logic [9:0]            sample_value = '0;
    logic [7:0]            sample_flags = '0;
    logic                  res_valid;
    logic                  res_ready    = 1'b0;
    logic                  pot_write;
    logic                  pot_channel;
    logic [7:0]            pot_setting;
    logic                  data_valid;
    logic                  data_port;
    logic [9:0]            data_value;
    logic [7:0]            data_flags;
    logic                  sample_request;
    logic                  sample_axis;
    logic                  calibrating;
    logic                  bad_axis;

    always #6 clk = ~clk;

    sensor_offset_trim_search_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .axis_select    (axis_select),
        .sample_port    (sample_port),
        .sample_value   (sample_value),
        .sample_flags   (sample_flags),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .pot_write      (pot_write),
        .pot_channel    (pot_channel),
        .pot_setting    (pot_setting),
        .data_valid     (data_valid),
        .data_port      (data_port),
        .data_value     (data_value),
        .data_flags     (data_flags),
        .sample_request (sample_request),
        .sample_axis    (sample_axis),
        .calibrating    (calibrating),
        .bad_axis       (bad_axis)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    item_t   pending_q[$];     // requests waiting for the driver
    result_t trim_expect_q[$]; // predicted results, oldest first
    item_t   cur_req;          // request currently on the port
    result_t want_r;

    cfg_t    trim_cfg;         // shadow of the register file
    state_t  trim_st;          // shadow of the search state

    int      errors         = 0;
    int      accepted_cnt   = 0;
    int      checked_cnt    = 0;
    int      settings_cnt   = 0;
    int      cal_done_cnt   = 0;
    int      bad_start_cnt  = 0;
    int      cycle_cnt      = 0;
    int      send_idle_pct  = 10;
    int      recv_stall_pct = 67;
    bit      hold_go        = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: one result per request, updates the shadow state
    // ------------------------------------------------------------------
    function automatic result_t trim_search_predict(input item_t it);
        result_t r;
        int      band_hi;
        int      band_lo;
        bit      above;
        bit      below;
        bit      do_write;
        r        = '0;
        do_write = 1'b0;
        case (it.req_type)
            REQ_START: begin
                if (it.axis_select <= 8'd1) begin
                    trim_st.cal_active  = 1'b1;
                    trim_st.step_now    = trim_cfg.initial_step;
                    trim_st.wiper_value = 8'd0;
                    trim_st.was_high    = 1'b1;
                    trim_st.steady_run  = 4'd0;
                    trim_st.time_up     = 1'b0;
                    trim_st.active_axis = it.axis_select[0];
                    r.pot_write         = 1'b1;
                    r.pot_channel       = it.axis_select[0];
                    r.pot_setting       = 8'd0;
                end else begin
                    // invalid axis: flag it and drop out of calibration
                    r.bad_axis         = 1'b1;
                    trim_st.cal_active = 1'b0;
                    bad_start_cnt++;
                end
            end
            REQ_SAMPLE: begin
                if (!trim_st.cal_active) begin
                    r.data_valid = 1'b1;
                    r.data_port  = it.sample_port;
                    r.data_value = it.sample_value;
                    r.data_flags = it.sample_flags;
                end else begin
                    // band edges without wrap; an edge off the ADC range never trips
                    band_hi = int'(trim_cfg.target_level) + int'(trim_cfg.window_half);
                    band_lo = int'(trim_cfg.target_level) - int'(trim_cfg.window_half);
                    above   = int'(it.sample_value) > band_hi;
                    below   = (band_lo >= 0) && (int'(it.sample_value) < band_lo);
                    do_write = 1'b1;
                    if (above) begin
                        if (!trim_st.was_high && trim_st.step_now != 8'd1)
                            trim_st.step_now = trim_st.step_now >> 1;
                        trim_st.wiper_value = trim_st.wiper_value + trim_st.step_now;
                        trim_st.was_high    = 1'b1;
                        trim_st.steady_run  = 4'd0;
                    end else if (below) begin
                        if (trim_st.was_high && trim_st.step_now != 8'd1)
                            trim_st.step_now = trim_st.step_now >> 1;
                        trim_st.wiper_value = trim_st.wiper_value - trim_st.step_now;
                        trim_st.was_high    = 1'b0;
                        trim_st.steady_run  = 4'd0;
                    end else if (trim_st.steady_run < trim_cfg.steady_needed) begin
                        trim_st.steady_run = trim_st.steady_run + 4'd1;
                    end else begin
                        // steady run complete: calibration ends, no pot write
                        trim_st.cal_active = 1'b0;
                        do_write           = 1'b0;
                        cal_done_cnt++;
                    end
                    if (do_write) begin
                        // write goes to the sample's channel, not the active axis
                        r.pot_write   = 1'b1;
                        r.pot_channel = it.sample_port;
                        r.pot_setting = trim_st.wiper_value;
                    end
                end
            end
            REQ_TIME_UP: begin
                trim_st.time_up = 1'b1;
            end
            REQ_WRITE_DONE: begin
                if (!trim_st.time_up) begin
                    r.sample_request = 1'b1;
                    r.sample_axis    = trim_st.active_axis;
                end else begin
                    trim_st.cal_active = 1'b0;
                end
            end
            default: ;
        endcase
        r.calibrating = trim_st.cal_active;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t item_of(input logic [1:0] rt, input logic [7:0] ax,
                                      input logic pt, input logic [9:0] v,
                                      input logic [7:0] fl);
        item_t it;
        it.req_type     = rt;
        it.axis_select  = ax;
        it.sample_port  = pt;
        it.sample_value = v;
        it.sample_flags = fl;
        return it;
    endfunction

    // random filler for the don't-care fields of a request
    function automatic item_t rand_req(input logic [1:0] rt);
        return item_of(rt, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       10'($urandom_range(1023)), 8'($urandom_range(255)));
    endfunction

    // ADC code placed in, above or below the band of the current setting
    function automatic logic [9:0] pick_value(input int where);
        int lo;
        int hi;
        lo = int'(trim_cfg.target_level) - int'(trim_cfg.window_half);
        hi = int'(trim_cfg.target_level) + int'(trim_cfg.window_half);
        if (lo < 0)
            lo = 0;
        if (hi > 1023)
            hi = 1023;
        case (where)
            PICK_IN:   return 10'($urandom_range(hi, lo));
            PICK_HIGH: return (hi < 1023) ? 10'($urandom_range(1023, hi + 1))
                                          : 10'($urandom_range(1023));
            PICK_LOW:  return (lo > 0) ? 10'($urandom_range(lo - 1, 0))
                                       : 10'($urandom_range(1023));
            default:   return 10'($urandom_range(1023));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_LEVEL:  trim_cfg.target_level  = val[9:0];
            CFG_WINDOW_HALF:   trim_cfg.window_half   = val[8:0];
            CFG_STEADY_NEEDED: trim_cfg.steady_needed = val[3:0];
            CFG_INITIAL_STEP:  trim_cfg.initial_step  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int tgt, input int win, input int stdy, input int stp);
        write_reg(CFG_TARGET_LEVEL,  CFG_DATA_W'(tgt));
        write_reg(CFG_WINDOW_HALF,   CFG_DATA_W'(win));
        write_reg(CFG_STEADY_NEEDED, CFG_DATA_W'(stdy));
        write_reg(CFG_INITIAL_STEP,  CFG_DATA_W'(stp));
        settings_cnt++;
    endtask

    // sender holds off until the core has returned everything it owes
    task automatic wait_drained();
        while (pending_q.size() != 0 || req_valid || trim_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly well-formed calibration runs (start, then write-done / sample
    // pairs), sprinkled with time-ups, bad starts, pass-through samples and noise.
    task automatic queue_random(input int n_items);
        int    queued;
        int    roll;
        int    p_in;
        int    run_len;
        int    where;
        item_t it;
        queued = 0;
        while (queued < n_items) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                p_in = ($urandom_range(2) == 0) ? 30 : (($urandom_range(1) == 0) ? 60 : 90);
                it = rand_req(REQ_START);
                it.axis_select = 8'($urandom_range(1));
                pending_q.push_back(it);
                queued++;
                run_len = $urandom_range(25, 3);
                for (int k = 0; k < run_len; k++) begin
                    if ($urandom_range(99) < 4) begin
                        pending_q.push_back(rand_req(REQ_TIME_UP));
                        queued++;
                    end
                    pending_q.push_back(rand_req(REQ_WRITE_DONE));
                    roll = $urandom_range(99);
                    if (roll < 5)
                        where = PICK_ANY;
                    else if (roll < p_in)
                        where = PICK_IN;
                    else
                        where = (roll[0]) ? PICK_HIGH : PICK_LOW;
                    it = rand_req(REQ_SAMPLE);
                    it.sample_value = pick_value(where);
                    pending_q.push_back(it);
                    queued += 2;
                end
            end else if (roll < 83) begin
                it = rand_req(REQ_START);
                it.axis_select = 8'($urandom_range(255, 2));
                pending_q.push_back(it);
                queued++;
            end else if (roll < 91) begin
                pending_q.push_back(rand_req(REQ_SAMPLE));
                queued++;
            end else begin
                pending_q.push_back(rand_req(2'($urandom_range(3))));
                queued++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: takes from pending_q, predicts on each accept
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                trim_expect_q.push_back(trim_search_predict(cur_req));
                accepted_cnt++;
            end
            // slot is free after this edge: offer the next request or go idle
            if (!req_valid || req_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_q.pop_front();
                    req_valid    <= 1'b1;
                    req_type     <= cur_req.req_type;
                    axis_select  <= cur_req.axis_select;
                    sample_port  <= cur_req.sample_port;
                    sample_value <= cur_req.sample_value;
                    sample_flags <= cur_req.sample_flags;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            // requests keep coming while results are blocked, so the core backs up
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: field-by-field compare against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            if (trim_expect_q.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
            end else begin
                want_r = trim_expect_q.pop_front();
                checked_cnt++;
                check_field("pot_write",      want_r.pot_write,      pot_write);
                check_field("pot_channel",    want_r.pot_channel,    pot_channel);
                check_field("pot_setting",    want_r.pot_setting,    pot_setting);
                check_field("data_valid",     want_r.data_valid,     data_valid);
                check_field("data_port",      want_r.data_port,      data_port);
                check_field("data_value",     want_r.data_value,     data_value);
                check_field("data_flags",     want_r.data_flags,     data_flags);
                check_field("sample_request", want_r.sample_request, sample_request);
                check_field("sample_axis",    want_r.sample_axis,    sample_axis);
                check_field("calibrating",    want_r.calibrating,    calibrating);
                check_field("bad_axis",       want_r.bad_axis,       bad_axis);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed requests, then random segments
    // ------------------------------------------------------------------
    initial begin
        trim_cfg = '{target_level: TARGET_LEVEL_RST, window_half: WINDOW_HALF_RST,
                     steady_needed: STEADY_NEEDED_RST, initial_step: INITIAL_STEP_RST};
        trim_st  = STATE_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pass, reset register values (target 512, band 496..528, steady 3)
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd0,    8'h00)); // idle pass-through
        pending_q.push_back(item_of(REQ_SAMPLE, 8'hff, 1'b1, 10'd1023, 8'hff));
        pending_q.push_back(item_of(REQ_START,  8'hff, 1'b0, 10'd0,    8'h00)); // bad axis
        pending_q.push_back(item_of(REQ_START,  8'h02, 1'b1, 10'd0,    8'h00)); // just past valid
        pending_q.push_back(item_of(REQ_START,  8'h01, 1'b0, 10'd0,    8'h00));
        pending_q.push_back(item_of(REQ_WRITE_DONE, 8'h00, 1'b0, 10'd0, 8'h00));
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd1023, 8'h5a)); // high
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b1, 10'd0,    8'ha5)); // low, halve
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd0,    8'h00)); // back to 0
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b1, 10'd0,    8'h00)); // wiper wraps
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd529,  8'h00)); // just above band
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd512,  8'h00)); // steady 1
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b1, 10'd496,  8'h00)); // low edge
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd528,  8'h00)); // high edge
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b1, 10'd520,  8'h00)); // run done
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b1, 10'd300,  8'h3c)); // passes again
        pending_q.push_back(item_of(REQ_START,  8'h00, 1'b0, 10'd0,    8'h00));
        pending_q.push_back(item_of(REQ_TIME_UP, 8'h00, 1'b0, 10'd0,   8'h00));
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd495,  8'h00)); // below band
        pending_q.push_back(item_of(REQ_WRITE_DONE, 8'h00, 1'b0, 10'd0, 8'h00)); // stops cal
        pending_q.push_back(item_of(REQ_WRITE_DONE, 8'h00, 1'b0, 10'd0, 8'h00)); // no request
        pending_q.push_back(item_of(REQ_SAMPLE, 8'h00, 1'b0, 10'd777,  8'h81));
        pending_q.push_back(item_of(REQ_START,  8'h01, 1'b1, 10'd0,    8'h00)); // clears time-up
        pending_q.push_back(item_of(REQ_WRITE_DONE, 8'h00, 1'b0, 10'd0, 8'h00));
        wait_drained();

        // Random segments, each under its own register setting
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            send_idle_pct  = (seg < 2) ? 10 : ((seg < 4) ? 67 : 0);
            recv_stall_pct = (seg < 2) ? 67 : ((seg < 4) ? 10 : 0);
            case (seg)
                1: apply_setting(0, 511, 0, 128);    // band covers the lower half of the range
                2: apply_setting(1023, 0, 15, 1);    // single-code band at the top
                3: apply_setting($urandom_range(1023), $urandom_range(64), // zero step
                                 $urandom_range(15), 0);
                default: apply_setting($urandom_range(1023), $urandom_range(64),
                                       $urandom_range(15), $urandom_range(128, 1));
            endcase
            queue_random(SEG_ITEMS);
            if (seg == 0)
                hold_go = 1'b1;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d requests (%0d results checked) over %0d register settings;",
                 accepted_cnt, checked_cnt, settings_cnt + 1);
        $display("%0d calibrations ran to a steady band, %0d starts had a bad axis.",
                 cal_done_cnt, bad_start_cnt);
        if (errors == 0 && trim_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sots_pkg.sv
rtl/core/sots_cfg_regs.sv
rtl/core/sots_step.sv
rtl/core/sensor_offset_trim_search_core.sv
dv/tb.sv
